// ===== sv/cct_pkg.sv =====
package cct_pkg;

    // request codes; code 7 is unused and leaves the clock alone
    typedef enum logic [2:0] {
        REQ_TICK  = 3'd0,
        REQ_SEC   = 3'd1,
        REQ_MIN   = 3'd2,
        REQ_HOUR  = 3'd3,
        REQ_DAY   = 3'd4,
        REQ_MONTH = 3'd5,
        REQ_YEAR  = 3'd6
    } t_req;

    localparam logic [8:0] SEC_MAX   = 9'd59;
    localparam logic [5:0] MIN_MAX   = 6'd59;
    localparam logic [4:0] HOUR_MAX  = 5'd23;
    localparam logic [3:0] MONTH_MAX = 4'd12;
    localparam logic [6:0] YEAR_LAST = 7'd99;
    localparam logic [7:0] YEAR_MOD  = 8'd100;
    localparam logic [7:0] YEAR_MOD2 = 8'd200;
    localparam logic [7:0] SEC_RST   = 8'd7;

    typedef struct packed {
        logic [7:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } t_cal;

    typedef struct packed {
        t_cal        cal;
        logic [31:0] word;
        logic        leap;
        logic [4:0]  mdays;
    } t_res;

    localparam t_cal CAL_RST = '{sec: SEC_RST, min: '0, hour: '0, day: '0,
                                 month: '0, year: '0};

    // 2000 + year, year below 100: only the divisible-by-4 test matters,
    // since 2000 itself is a 400-year leap year
    function automatic logic f_leap(input logic [6:0] year);
        f_leap = (year[1:0] == 2'b00);
    endfunction

    function automatic logic [4:0] f_month_days(input logic [3:0] month,
                                                input logic [6:0] year);
        logic [4:0] d;
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                   d = 5'd30;
            4'd2:    d = f_leap(year) ? 5'd29 : 5'd28;
            default: d = 5'd0;
        endcase
        f_month_days = d;
    endfunction

    function automatic logic [31:0] f_type_f(input t_cal cal);
        f_type_f = {cal.year[6:3], cal.month, cal.year[2:0], cal.day, 3'b000,
                    cal.hour, 2'b00, cal.min};
    endfunction

endpackage

// ===== sv/cct_ifs.sv =====
interface cct_req_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] value;

    modport source (output valid, req_type, value, input ready);
    modport sink   (input valid, req_type, value, output ready);
endinterface

interface cct_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [6:0]  year_of_century;
    logic [31:0] type_f_word;
    logic        leap_year;
    logic [4:0]  month_days;

    modport source (output valid, seconds, minutes, hour, day, month, year_of_century,
                    type_f_word, leap_year, month_days, input ready);
    modport sink   (input valid, seconds, minutes, hour, day, month, year_of_century,
                    type_f_word, leap_year, month_days, output ready);
endinterface

// ===== sv/cct_step.sv =====
module cct_step (
    input  cct_pkg::t_cal i_cal,
    input  logic [2:0]    i_req,
    input  logic [7:0]    i_value,
    output cct_pkg::t_cal o_cal,
    output cct_pkg::t_res o_res
);
    import cct_pkg::*;

    logic [8:0] sec_inc;
    logic [5:0] min_inc;
    logic [4:0] hour_inc;
    logic [4:0] day_inc;
    logic [3:0] mon_inc;
    logic [4:0] cur_days;
    logic [7:0] year_wr;
    t_cal       cal;

    assign sec_inc  = {1'b0, i_cal.sec} + 9'd1;
    assign min_inc  = i_cal.min + 6'd1;
    assign hour_inc = i_cal.hour + 5'd1;
    assign day_inc  = i_cal.day + 5'd1;
    assign mon_inc  = i_cal.month + 4'd1;
    assign cur_days = f_month_days(i_cal.month, i_cal.year);

    always_comb begin
        if (i_value >= YEAR_MOD2) begin
            year_wr = i_value - YEAR_MOD2;
        end else if (i_value >= YEAR_MOD) begin
            year_wr = i_value - YEAR_MOD;
        end else begin
            year_wr = i_value;
        end
    end

    // carry chain on a tick: each field only moves when all lower fields overflow; writes set one field
    always_comb begin
        cal = i_cal;
        unique case (t_req'(i_req))
            REQ_TICK: begin
                if (sec_inc <= SEC_MAX) begin
                    cal.sec = sec_inc[7:0];
                end else begin
                    cal.sec = '0;
                    if (min_inc <= MIN_MAX) begin
                        cal.min = min_inc;
                    end else begin
                        cal.min = '0;
                        if (hour_inc <= HOUR_MAX) begin
                            cal.hour = hour_inc;
                        end else begin
                            cal.hour = '0;
                            if (day_inc != 5'd0 && day_inc <= cur_days) begin
                                cal.day = day_inc;
                            end else begin
                                cal.day = 5'd1;
                                if (mon_inc <= MONTH_MAX) begin
                                    cal.month = mon_inc;
                                end else begin
                                    cal.month = 4'd1;
                                    cal.year  = (i_cal.year == YEAR_LAST) ? 7'd0
                                                                          : i_cal.year + 7'd1;
                                end
                            end
                        end
                    end
                end
            end
            REQ_SEC:   cal.sec   = i_value;
            REQ_MIN:   cal.min   = i_value[5:0];
            REQ_HOUR:  cal.hour  = i_value[4:0];
            REQ_DAY:   cal.day   = i_value[4:0];
            REQ_MONTH: cal.month = i_value[3:0];
            REQ_YEAR:  cal.year  = year_wr[6:0];
            default: ;
        endcase
    end

    assign o_cal       = cal;
    assign o_res.cal   = cal;
    assign o_res.word  = f_type_f(cal);
    assign o_res.leap  = f_leap(cal.year);
    assign o_res.mdays = f_month_days(cal.month, cal.year);

endmodule

// ===== sv/calendar_clock_type_f.sv =====
// Channel    Dir  Payload                                            Handshake
// i_req_ch   in   req_type[2:0], value[7:0]                          valid/ready
// o_res_ch   out  seconds..year_of_century, type_f_word, leap_year,  valid/ready
//                 month_days
//
// One transaction per cycle sustained while results are taken. A transaction
// passes the input register, then next-state logic into the result register.
// i_rst_n is synchronous: clock returns to 00:00:07, day 0, month 0, year 0.
// A stalled result holds the clock state; the input register still takes one
// transaction, then ready drops until the result is taken.
module calendar_clock_type_f (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cct_req_if.sink          i_req_ch,
    cct_res_if.source        o_res_ch
);
    import cct_pkg::*;

    // input stage
    logic       r_in_valid;
    logic [2:0] r_in_req;
    logic [7:0] r_in_value;

    // clock state and result stage
    t_cal r_cal;
    t_cal n_cal;
    t_res r_res;
    t_res n_res;
    logic r_out_valid;

    logic adv_out;   // input stage moves into the result register
    logic adv_in;    // new transaction taken from the port

    assign adv_out = r_in_valid && (!r_out_valid || o_res_ch.ready);
    assign adv_in  = i_req_ch.valid && i_req_ch.ready;

    assign i_req_ch.ready = !r_in_valid || adv_out;

    cct_step u_step (
        .i_cal   (r_cal),
        .i_req   (r_in_req),
        .i_value (r_in_value),
        .o_cal   (n_cal),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal       <= CAL_RST;
        end else begin
            if (adv_in) begin
                r_in_valid <= 1'b1;
            end else if (adv_out) begin
                r_in_valid <= 1'b0;
            end
            if (adv_out) begin
                r_out_valid <= 1'b1;
                r_cal       <= n_cal;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (adv_in) begin
            r_in_req   <= i_req_ch.req_type;
            r_in_value <= i_req_ch.value;
        end
        if (adv_out) begin
            r_res <= n_res;
        end
    end

    assign o_res_ch.valid           = r_out_valid;
    assign o_res_ch.seconds         = r_res.cal.sec;
    assign o_res_ch.minutes         = r_res.cal.min;
    assign o_res_ch.hour            = r_res.cal.hour;
    assign o_res_ch.day             = r_res.cal.day;
    assign o_res_ch.month           = r_res.cal.month;
    assign o_res_ch.year_of_century = r_res.cal.year;
    assign o_res_ch.type_f_word     = r_res.word;
    assign o_res_ch.leap_year       = r_res.leap;
    assign o_res_ch.month_days      = r_res.mdays;

`ifndef SYNTHESIS
    // year stays within the century
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cal.year < 7'd100)
        else $error("year out of range");

    // clock state frozen while a result is stalled
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_res_ch.ready |=> $stable(r_cal))
        else $error("clock state moved under stall");

    // a shown result matches the clock state
    a_res_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_res.cal == r_cal)
        else $error("result differs from clock state");

    // months without a length report zero days
    a_mdays_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ((r_res.mdays == 5'd0) ==
                         (r_res.cal.month == 4'd0 || r_res.cal.month > 4'd12)))
        else $error("month length mismatch");

    // blocked input stage keeps its transaction
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv_out |=> r_in_valid && $stable(r_in_req) && $stable(r_in_value))
        else $error("input stage lost a transaction");
`endif

endmodule
